@@ rtl/core/qrs_pkg.sv @@
package qrs_pkg;

    // Root-count codes as they appear on the result port.
    typedef enum logic [2:0] {
        CNT_NONE = 3'd0,
        CNT_ONE  = 3'd1,
        CNT_TWO  = 3'd2,
        CNT_INF  = 3'd3
    } t_count;

    // Which divisions the back end has to carry out for an equation.
    typedef enum logic [2:0] {
        MODE_NONE   = 3'd0,
        MODE_LIN    = 3'd1,
        MODE_CZERO  = 3'd2,
        MODE_DOUBLE = 3'd3,
        MODE_TWO    = 3'd4
    } t_mode;

    // Classification handed from the front end to the back end.
    typedef struct packed {
        t_mode  mode;
        t_count cnt;
        logic   sa;
        logic   sb;
        logic   bpos;
        logic   cpos;
    } t_ctrl;

    localparam int THR_W      = 16;
    localparam int QUOT_W     = 64;
    localparam int FIFO_DEPTH = 8;
    localparam int FRONT_LAT  = 3;

    localparam logic [THR_W-1:0]  THR_RESET = 16'd1;
    localparam logic [QUOT_W-1:0] SAT_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [QUOT_W-1:0] SAT_MIN   = 64'h8000_0000_0000_0000;

endpackage

@@ rtl/core/quadratic_root_solver_unit.sv @@
// Quadratic root solver: solves a*x^2 + b*x + c = 0 for signed Q16.16 coefficients and
// returns a root count with up to two roots in signed Q32.32, saturated. An equation is
// taken on any edge with start high and busy low, one per cycle without gaps; busy does
// not rise in normal operation, because the back end never stalls. Each result appears
// for one cycle with o_strobe, in order; most of the pipeline is the bit-per-stage square
// root (COEFF_WIDTH + 17 stages) and the dividers (64 quotient-bit stages and a saturating
// sign stage each). The receiver cannot stall, so results must be taken as they come. The
// user must write the zero threshold through i_cfg_we / i_cfg_wdata only while no equation
// is in flight; the block itself does not enforce this.
module quadratic_root_solver_unit #(
    parameter int COEFF_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [31:0]                 i_coeff_a,
    input  logic [31:0]                 i_coeff_b,
    input  logic [31:0]                 i_coeff_c,
    input  logic                        i_cfg_we,
    input  logic [qrs_pkg::THR_W-1:0]   i_cfg_wdata,
    output logic                        o_strobe,
    output logic [2:0]                  o_root_count,
    output logic signed [63:0]          o_root_first,
    output logic signed [63:0]          o_root_second
);

    localparam int CW      = COEFF_WIDTH;
    localparam int DMW     = 2 * CW + 1;
    localparam int RW      = CW + 17;
    localparam int DW      = CW + 1;
    localparam int QW      = qrs_pkg::QUOT_W;
    localparam int NW      = QW + DW;
    localparam int NBW     = CW + 19;
    localparam int DIV_LAT = QW + 1;
    localparam int CTW     = $bits(qrs_pkg::t_ctrl);
    localparam int FW      = CTW + 4 * CW + DMW;
    localparam int FCW     = $clog2(qrs_pkg::FIFO_DEPTH + 1);

    logic [qrs_pkg::THR_W-1:0] r_thr;

    logic                  f_valid;
    qrs_pkg::t_ctrl        f_ctrl;
    logic [CW-1:0]         f_ma, f_mb, f_mc;
    logic signed [CW-1:0]  f_b;
    logic [DMW-1:0]        f_dmag;

    logic [FW-1:0]         q_dout;
    logic [FCW-1:0]        q_count;
    logic                  h_valid;
    qrs_pkg::t_ctrl        h_ctrl;
    logic [CW-1:0]         h_ma, h_mb, h_mc, h_b;
    logic [DMW-1:0]        h_dmag;

    logic [RW-1:0]         s_root;

    logic                  d_valid [RW];
    qrs_pkg::t_ctrl        d_ctrl  [RW];
    logic [CW-1:0]         d_ma    [RW];
    logic [CW-1:0]         d_mb    [RW];
    logic [CW-1:0]         d_mc    [RW];
    logic [CW-1:0]         d_b     [RW];

    qrs_pkg::t_ctrl        s_ctrl;
    logic signed [NBW-1:0] nb, n1, n2;
    logic [NBW-1:0]        m1, m2;
    logic [NW-1:0]         n_num1, n_num2;
    logic [DW-1:0]         n_den1, n_den2;
    logic                  n_neg1, n_neg2, n_u1, n_u2;

    logic                  r_nvalid, r_neg1, r_neg2, r_u1, r_u2;
    qrs_pkg::t_count       r_ncnt;
    logic [NW-1:0]         r_num1, r_num2;
    logic [DW-1:0]         r_den1, r_den2;

    logic [QW-1:0]         quot1, quot2;

    logic                  e_valid [DIV_LAT];
    qrs_pkg::t_count       e_cnt   [DIV_LAT];
    logic                  e_u1    [DIV_LAT];
    logic                  e_u2    [DIV_LAT];

    // Zero threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= qrs_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // Front end: classification and discriminant.
    qrs_front #(.COEFF_WIDTH(CW)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start && !busy),
        .i_coeff_a (i_coeff_a),
        .i_coeff_b (i_coeff_b),
        .i_coeff_c (i_coeff_c),
        .i_thr     (r_thr),
        .o_valid   (f_valid),
        .o_ctrl    (f_ctrl),
        .o_ma      (f_ma),
        .o_mb      (f_mb),
        .o_mc      (f_mc),
        .o_b       (f_b),
        .o_dmag    (f_dmag)
    );

    // Queue between the two halves; busy keeps room for beats still in the front end.
    qrs_fifo #(.WIDTH(FW), .DEPTH(qrs_pkg::FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_ctrl, f_ma, f_mb, f_mc, f_b, f_dmag}),
        .i_pop   (h_valid),
        .o_data  (q_dout),
        .o_count (q_count)
    );

    assign busy    = q_count >= FCW'(qrs_pkg::FIFO_DEPTH - qrs_pkg::FRONT_LAT);
    assign h_valid = q_count != '0;
    assign {h_ctrl, h_ma, h_mb, h_mc, h_b, h_dmag} = q_dout;

    // Square root of the discriminant, with 32 fractional bits (Q17.32 at the default width).
    qrs_sqrt #(.ROOT_W(RW)) u_sqrt (
        .i_clk  (i_clk),
        .i_rad  ((2*RW)'({h_dmag, 32'h0000_0000})),
        .o_root (s_root)
    );

    // Side data follows the square root stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RW; k++) begin
                d_valid[k] <= 1'b0;
            end
        end else begin
            d_valid[0] <= h_valid;
            for (int k = 1; k < RW; k++) begin
                d_valid[k] <= d_valid[k-1];
            end
        end
        d_ctrl[0] <= h_ctrl;
        d_ma[0]   <= h_ma;
        d_mb[0]   <= h_mb;
        d_mc[0]   <= h_mc;
        d_b[0]    <= h_b;
        for (int k = 1; k < RW; k++) begin
            d_ctrl[k] <= d_ctrl[k-1];
            d_ma[k]   <= d_ma[k-1];
            d_mb[k]   <= d_mb[k-1];
            d_mc[k]   <= d_mc[k-1];
            d_b[k]    <= d_b[k-1];
        end
    end

    // Numerators, divisors and signs of the divisions for each case.
    assign s_ctrl = d_ctrl[RW-1];

    always_comb begin
        nb = -(NBW'($signed(d_b[RW-1])) <<< 16);
        n1 = nb + $signed(NBW'(s_root));
        n2 = nb - $signed(NBW'(s_root));
        m1 = n1[NBW-1] ? NBW'(-n1) : NBW'(n1);
        m2 = n2[NBW-1] ? NBW'(-n2) : NBW'(n2);

        n_num1 = '0;
        n_num2 = '0;
        n_den1 = '0;
        n_den2 = '0;
        n_neg1 = 1'b0;
        n_neg2 = 1'b0;
        n_u1   = 1'b0;
        n_u2   = 1'b0;
        unique case (s_ctrl.mode)
            qrs_pkg::MODE_LIN: begin
                n_num1 = NW'({d_mc[RW-1], 32'h0000_0000});
                n_den1 = DW'(d_mb[RW-1]);
                n_neg1 = s_ctrl.cpos != s_ctrl.sb;
                n_u1   = 1'b1;
            end
            qrs_pkg::MODE_CZERO: begin
                n_num2 = NW'({d_mb[RW-1], 32'h0000_0000});
                n_den2 = DW'(d_ma[RW-1]);
                n_neg2 = s_ctrl.bpos != s_ctrl.sa;
                n_u2   = 1'b1;
            end
            qrs_pkg::MODE_DOUBLE: begin
                n_num1 = NW'({d_mb[RW-1], 32'h0000_0000});
                n_den1 = {d_ma[RW-1], 1'b0};
                n_neg1 = s_ctrl.bpos != s_ctrl.sa;
                n_u1   = 1'b1;
            end
            qrs_pkg::MODE_TWO: begin
                n_num1 = NW'({m1, 16'h0000});
                n_num2 = NW'({m2, 16'h0000});
                n_den1 = {d_ma[RW-1], 1'b0};
                n_den2 = {d_ma[RW-1], 1'b0};
                n_neg1 = n1[NBW-1] != s_ctrl.sa;
                n_neg2 = n2[NBW-1] != s_ctrl.sa;
                n_u1   = 1'b1;
                n_u2   = 1'b1;
            end
            default: begin
                n_u1 = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nvalid <= 1'b0;
        end else begin
            r_nvalid <= d_valid[RW-1];
        end
        r_ncnt <= s_ctrl.cnt;
        r_num1 <= n_num1;
        r_num2 <= n_num2;
        r_den1 <= n_den1;
        r_den2 <= n_den2;
        r_neg1 <= n_neg1;
        r_neg2 <= n_neg2;
        r_u1   <= n_u1;
        r_u2   <= n_u2;
    end

    // Two dividers, one for each root.
    qrs_div #(.DEN_W(DW)) u_div1 (
        .i_clk  (i_clk),
        .i_num  (r_num1),
        .i_den  (r_den1),
        .i_neg  (r_neg1),
        .o_quot (quot1)
    );

    qrs_div #(.DEN_W(DW)) u_div2 (
        .i_clk  (i_clk),
        .i_num  (r_num2),
        .i_den  (r_den2),
        .i_neg  (r_neg2),
        .o_quot (quot2)
    );

    // Count and root-use flags follow the divider stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                e_valid[k] <= 1'b0;
            end
        end else begin
            e_valid[0] <= r_nvalid;
            for (int k = 1; k < DIV_LAT; k++) begin
                e_valid[k] <= e_valid[k-1];
            end
        end
        e_cnt[0] <= r_ncnt;
        e_u1[0]  <= r_u1;
        e_u2[0]  <= r_u2;
        for (int k = 1; k < DIV_LAT; k++) begin
            e_cnt[k] <= e_cnt[k-1];
            e_u1[k]  <= e_u1[k-1];
            e_u2[k]  <= e_u2[k-1];
        end
    end

    // Result register: a root that is not produced reads zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= e_valid[DIV_LAT-1];
        end
        o_root_count  <= e_cnt[DIV_LAT-1];
        o_root_first  <= e_u1[DIV_LAT-1] ? $signed(quot1) : 64'sd0;
        o_root_second <= e_u2[DIV_LAT-1] ? $signed(quot2) : 64'sd0;
    end

endmodule

@@ rtl/core/qrs_front.sv @@
module qrs_front #(
    parameter int COEFF_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [31:0]                   i_coeff_a,
    input  logic [31:0]                   i_coeff_b,
    input  logic [31:0]                   i_coeff_c,
    input  logic [qrs_pkg::THR_W-1:0]     i_thr,
    output logic                          o_valid,
    output qrs_pkg::t_ctrl                o_ctrl,
    output logic [COEFF_WIDTH-1:0]        o_ma,
    output logic [COEFF_WIDTH-1:0]        o_mb,
    output logic [COEFF_WIDTH-1:0]        o_mc,
    output logic signed [COEFF_WIDTH-1:0] o_b,
    output logic [2*COEFF_WIDTH:0]        o_dmag
);

    localparam int CW  = COEFF_WIDTH;
    localparam int PW  = 2 * CW;
    localparam int DMW = 2 * CW + 1;

    function automatic logic [CW-1:0] mag(input logic [CW-1:0] v);
        return v[CW-1] ? (~v + 1'b1) : v;
    endfunction

    logic [CW-1:0] a_w, b_w, c_w, ma_w, mb_w, mc_w, thr_w;

    logic          r1_valid, r1_sa, r1_sb, r1_sc, r1_bpos, r1_cpos, r1_za, r1_zb, r1_zc;
    logic [CW-1:0] r1_ma, r1_mb, r1_mc, r1_b;

    logic          r2_valid, r2_sa, r2_sb, r2_sc, r2_bpos, r2_cpos, r2_za, r2_zb, r2_zc;
    logic [CW-1:0] r2_ma, r2_mb, r2_mc, r2_b;
    logic [PW-1:0] r2_bsq, r2_pac;

    logic [PW+1:0]  bsq_x, fac, sum_d, dm_full;
    logic [DMW-1:0] dmag;
    logic           diff_sign, bsq_ge, dneg, dsmall;
    qrs_pkg::t_ctrl n_ctrl;

    // Stage one: take the low COEFF_WIDTH bits of each coefficient, magnitudes and zero tests.
    assign a_w   = i_coeff_a[CW-1:0];
    assign b_w   = i_coeff_b[CW-1:0];
    assign c_w   = i_coeff_c[CW-1:0];
    assign ma_w  = mag(a_w);
    assign mb_w  = mag(b_w);
    assign mc_w  = mag(c_w);
    assign thr_w = CW'(i_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
        r1_ma   <= ma_w;
        r1_mb   <= mb_w;
        r1_mc   <= mc_w;
        r1_b    <= b_w;
        r1_sa   <= a_w[CW-1];
        r1_sb   <= b_w[CW-1];
        r1_sc   <= c_w[CW-1];
        r1_bpos <= !b_w[CW-1] && (b_w != '0);
        r1_cpos <= !c_w[CW-1] && (c_w != '0);
        r1_za   <= ma_w < thr_w;
        r1_zb   <= mb_w < thr_w;
        r1_zc   <= mc_w < thr_w;
    end

    // Stage two: the two products of the discriminant.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_bsq  <= r1_mb * r1_mb;
        r2_pac  <= r1_ma * r1_mc;
        r2_ma   <= r1_ma;
        r2_mb   <= r1_mb;
        r2_mc   <= r1_mc;
        r2_b    <= r1_b;
        r2_sa   <= r1_sa;
        r2_sb   <= r1_sb;
        r2_sc   <= r1_sc;
        r2_bpos <= r1_bpos;
        r2_cpos <= r1_cpos;
        r2_za   <= r1_za;
        r2_zb   <= r1_zb;
        r2_zc   <= r1_zc;
    end

    // Stage three: discriminant magnitude and sign, then the case split.
    always_comb begin
        bsq_x     = {2'b00, r2_bsq};
        fac       = {r2_pac, 2'b00};
        sum_d     = bsq_x + fac;
        diff_sign = r2_sa != r2_sc;
        bsq_ge    = bsq_x >= fac;
        if (diff_sign) begin
            dm_full = sum_d;
        end else if (bsq_ge) begin
            dm_full = bsq_x - fac;
        end else begin
            dm_full = fac - bsq_x;
        end
        dmag   = dm_full[DMW-1:0];
        dneg   = !diff_sign && !bsq_ge;
        dsmall = dmag < DMW'({i_thr, 16'h0000});
    end

    always_comb begin
        n_ctrl.sa   = r2_sa;
        n_ctrl.sb   = r2_sb;
        n_ctrl.bpos = r2_bpos;
        n_ctrl.cpos = r2_cpos;
        priority if (r2_za && r2_zb) begin
            n_ctrl.cnt  = r2_zc ? qrs_pkg::CNT_INF : qrs_pkg::CNT_NONE;
            n_ctrl.mode = qrs_pkg::MODE_NONE;
        end else if (r2_za) begin
            n_ctrl.cnt  = qrs_pkg::CNT_ONE;
            n_ctrl.mode = r2_zc ? qrs_pkg::MODE_NONE : qrs_pkg::MODE_LIN;
        end else if (r2_zc && r2_zb) begin
            n_ctrl.cnt  = qrs_pkg::CNT_ONE;
            n_ctrl.mode = qrs_pkg::MODE_NONE;
        end else if (r2_zc) begin
            n_ctrl.cnt  = qrs_pkg::CNT_TWO;
            n_ctrl.mode = qrs_pkg::MODE_CZERO;
        end else if (dsmall) begin
            n_ctrl.cnt  = qrs_pkg::CNT_ONE;
            n_ctrl.mode = qrs_pkg::MODE_DOUBLE;
        end else if (dneg) begin
            n_ctrl.cnt  = qrs_pkg::CNT_NONE;
            n_ctrl.mode = qrs_pkg::MODE_NONE;
        end else begin
            n_ctrl.cnt  = qrs_pkg::CNT_TWO;
            n_ctrl.mode = qrs_pkg::MODE_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r2_valid;
        end
        o_ctrl <= n_ctrl;
        o_ma   <= r2_ma;
        o_mb   <= r2_mb;
        o_mc   <= r2_mc;
        o_b    <= $signed(r2_b);
        o_dmag <= dmag;
    end

endmodule

@@ rtl/core/qrs_fifo.sv @@
module qrs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    // DEPTH must be a power of two so that the pointers wrap by themselves; the block does not check this.
    localparam int AW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [NW-1:0]    r_count, n_count;

    // Occupancy follows pushes and pops.
    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

@@ rtl/core/qrs_sqrt.sv @@
module qrs_sqrt #(
    parameter int ROOT_W = 49
) (
    input  logic                  i_clk,
    input  logic [2*ROOT_W-1:0]   i_rad,
    output logic [ROOT_W-1:0]     o_root
);

    localparam int RW = ROOT_W;
    localparam int XW = 2 * RW;
    localparam int MW = RW + 2;

    // One result bit per stage, ROOT_W stages.
    logic [MW-1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [XW-1:0] r_x    [RW];

    for (genvar k = 0; k < RW; k++) begin : g_st
        logic [MW-1:0] c_rem;
        logic [RW-1:0] c_root;
        logic [XW-1:0] c_x;
        logic [MW+1:0] t, diff;
        logic          ge;

        if (k == 0) begin : g_in
            assign c_rem  = '0;
            assign c_root = '0;
            assign c_x    = i_rad;
        end else begin : g_pipe
            assign c_rem  = r_rem[k-1];
            assign c_root = r_root[k-1];
            assign c_x    = r_x[k-1];
        end

        // Bring down two bits and try subtracting 4*root+1.
        always_comb begin
            t    = {c_rem, c_x[XW-1 -: 2]};
            diff = t - {2'b00, c_root, 2'b01};
            ge   = t >= {2'b00, c_root, 2'b01};
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= ge ? diff[MW-1:0] : t[MW-1:0];
            r_root[k] <= {c_root[RW-2:0], ge};
            r_x[k]    <= c_x << 2;
        end
    end

    assign o_root = r_root[RW-1];

endmodule

@@ rtl/core/qrs_div.sv @@
module qrs_div #(
    parameter int DEN_W = 33
) (
    input  logic                               i_clk,
    input  logic [qrs_pkg::QUOT_W+DEN_W-1:0]   i_num,
    input  logic [DEN_W-1:0]                   i_den,
    input  logic                               i_neg,
    output logic [qrs_pkg::QUOT_W-1:0]         o_quot
);

    localparam int QW = qrs_pkg::QUOT_W;

    // One quotient bit per stage, then a saturating sign stage.
    logic [DEN_W-1:0] r_rem [QW];
    logic [QW-1:0]    r_low [QW];
    logic [QW-1:0]    r_q   [QW];
    logic [DEN_W-1:0] r_den [QW];
    logic             r_neg [QW];
    logic             r_ovf [QW];
    logic [QW-1:0]    q_end;

    for (genvar k = 0; k < QW; k++) begin : g_st
        logic [DEN_W-1:0] c_rem, c_den;
        logic [QW-1:0]    c_low, c_q;
        logic             c_neg, c_ovf;
        logic [DEN_W:0]   t, diff;
        logic             ge;

        if (k == 0) begin : g_in
            // The quotient overflows 64 bits exactly when the top part reaches the divisor.
            assign c_rem = i_num[QW+DEN_W-1:QW];
            assign c_low = i_num[QW-1:0];
            assign c_q   = '0;
            assign c_den = i_den;
            assign c_neg = i_neg;
            assign c_ovf = i_num[QW+DEN_W-1:QW] >= i_den;
        end else begin : g_pipe
            assign c_rem = r_rem[k-1];
            assign c_low = r_low[k-1];
            assign c_q   = r_q[k-1];
            assign c_den = r_den[k-1];
            assign c_neg = r_neg[k-1];
            assign c_ovf = r_ovf[k-1];
        end

        always_comb begin
            t    = {c_rem, c_low[QW-1]};
            diff = t - {1'b0, c_den};
            ge   = t >= {1'b0, c_den};
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
            r_low[k] <= c_low << 1;
            r_q[k]   <= {c_q[QW-2:0], ge};
            r_den[k] <= c_den;
            r_neg[k] <= c_neg;
            r_ovf[k] <= c_ovf;
        end
    end

    // Apply the sign and clamp to the signed 64-bit range.
    assign q_end = r_q[QW-1];

    always_ff @(posedge i_clk) begin
        if (r_ovf[QW-1]) begin
            o_quot <= r_neg[QW-1] ? qrs_pkg::SAT_MIN : qrs_pkg::SAT_MAX;
        end else if (r_neg[QW-1]) begin
            o_quot <= (q_end > qrs_pkg::SAT_MIN) ? qrs_pkg::SAT_MIN : (~q_end + 1'b1);
        end else begin
            o_quot <= (q_end > qrs_pkg::SAT_MAX) ? qrs_pkg::SAT_MAX : q_end;
        end
    end

endmodule

@@ rtl/core/qrs_checker.sv @@
module qrs_checker #(
    parameter int COEFF_WIDTH = 32
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [31:0]                 i_coeff_a,
    input logic [31:0]                 i_coeff_b,
    input logic [31:0]                 i_coeff_c,
    input logic                        i_cfg_we,
    input logic [qrs_pkg::THR_W-1:0]   i_cfg_wdata,
    input logic                        o_strobe,
    input logic [2:0]                  o_root_count,
    input logic signed [63:0]          o_root_first,
    input logic signed [63:0]          o_root_second
);

    // LAT spans the pipeline from the accepting edge to the edge on which the strobe is sampled.
    localparam int LAT = COEFF_WIDTH + 88;

    // Every result beat goes back to an earlier accepted beat.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result beat without a matching accepted beat");

    // The back end never stalls, so the queue never backs up.
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_root_count == qrs_pkg::CNT_NONE || o_root_count == qrs_pkg::CNT_ONE
                      || o_root_count == qrs_pkg::CNT_TWO || o_root_count == qrs_pkg::CNT_INF))
        else $error("root count out of range");

    // No roots or infinitely many: both root fields read zero.
    a_zero_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_root_count == qrs_pkg::CNT_NONE || o_root_count == qrs_pkg::CNT_INF))
        |-> (o_root_first == 64'sd0 && o_root_second == 64'sd0))
        else $error("root set where none is produced");

    a_one_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_root_count == qrs_pkg::CNT_ONE) |-> o_root_second == 64'sd0)
        else $error("second root set for a single root");

endmodule

bind quadratic_root_solver_unit qrs_checker #(.COEFF_WIDTH(COEFF_WIDTH)) u_qrs_checker (.*);
